FILE: rtl/tpsb_pkg.sv
`default_nettype none
package tpsb_pkg;

    localparam int MaxBeamsDefault = 256;
    localparam int CordicSteps     = 24;

    localparam logic [2:0] RegSensorX  = 3'd0;
    localparam logic [2:0] RegSensorY  = 3'd1;
    localparam logic [2:0] RegMinAngle = 3'd2;
    localparam logic [2:0] RegMaxAngle = 3'd3;
    localparam logic [2:0] RegMinDist  = 3'd4;
    localparam logic [2:0] RegMaxDist  = 3'd5;
    localparam logic [2:0] RegAngRes   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQUARE,
        ST_CORDIC,
        ST_SQRT,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic square;
        logic cordic;
        logic sqrt_step;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic keep;
    } t_status;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tpsb_ctrl.sv
`default_nettype none
module tpsb_ctrl
    import tpsb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_cnt        = '0;
                n_state      = ST_CORDIC;
            end
            ST_CORDIC: begin
                o_cmd.cordic = 1'b1;
                n_cnt        = r_cnt + 5'd1;
                if (r_cnt == 5'(CordicSteps - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // One step per bit pair of the 34-bit radicand.
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_cnt   = '0;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'd17) begin
                    n_cnt   = '0;
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = i_status.keep;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/tpsb_datapath.sv
`default_nettype none
module tpsb_datapath
    import tpsb_pkg::*;
#(
    parameter int MAX_BEAMS = MaxBeamsDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [15:0] i_point_x,
    input  wire logic signed [15:0] i_point_y,
    input  wire logic               i_first_point,
    input  wire logic signed [15:0] i_sensor_x,
    input  wire logic signed [15:0] i_sensor_y,
    input  wire logic signed [15:0] i_min_angle,
    input  wire logic signed [15:0] i_max_angle,
    input  wire logic        [16:0] i_min_distance,
    input  wire logic        [16:0] i_max_distance,
    input  wire logic        [14:0] i_angular_resolution,
    output t_status                 o_status,
    output logic             [16:0] o_beam_range,
    output logic signed      [15:0] o_beam_angle,
    output logic             [15:0] o_scan_index,
    output logic             [7:0]  o_beam_slot,
    output logic                    o_dropped
);

    localparam int CntW = $clog2(MAX_BEAMS + 1);

    logic signed [16:0] r_dx, r_dy;
    logic               r_first;
    logic        [33:0] r_sq;       // dx*dx + dy*dy
    logic               r_dist_ok;
    logic signed [42:0] r_cx, r_cy;
    logic        [31:0] r_acc;
    logic        [4:0]  r_step;
    logic               r_zero;
    logic        [33:0] r_rem;
    logic        [17:0] r_root;
    logic        [4:0]  r_sq_step;
    logic        [17:0] r_dnum;
    logic        [17:0] r_quot;
    logic        [16:0] r_drem;
    logic        [4:0]  r_dv_step;
    logic        [CntW-1:0] r_count;
    logic        [16:0] r_range_q;
    logic signed [15:0] r_ang_q;
    logic        [15:0] r_idx_q;
    logic        [7:0]  r_slot_q;
    logic               r_drop_q;

    logic signed [15:0] w_ang;
    logic signed [42:0] w_xs, w_ys;
    logic        [15:0] w_a16;
    logic        [17:0] w_root2;
    logic        [35:0] w_trial;
    logic        [33:0] w_low;
    logic        [16:0] w_res;
    logic        [17:0] w_dtrial;
    logic               w_ang_ok;
    logic        [16:0] w_diff;

    assign w_xs  = r_cx >>> r_step;
    assign w_ys  = r_cy >>> r_step;
    assign w_a16 = 16'((r_acc + 32'h8000) >> 16);
    assign w_ang = r_zero ? 16'sd0 : $signed(w_a16);
    assign w_ang_ok = (w_ang >= i_min_angle) && (w_ang <= i_max_angle);
    assign o_status.keep = w_ang_ok && r_dist_ok;
    assign w_res = (i_angular_resolution == 15'd0) ? 17'd2 : {1'b0, i_angular_resolution, 1'b0};
    assign w_diff = 17'($signed({w_ang[15], w_ang}) - $signed({i_min_angle[15], i_min_angle}));

    // Restoring square root, one result bit per step over the 34-bit radicand (17 steps).
    assign w_low   = r_sq << {r_sq_step, 1'b0};
    assign w_trial = {r_rem, w_low[33:32]} - {16'd0, r_root, 2'b01};
    assign w_root2 = r_root;

    assign w_dtrial = {r_drem, r_dnum[17]} - {1'b0, w_res};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx    <= 17'(i_point_x) - 17'(i_sensor_x);
            r_dy    <= 17'(i_point_y) - 17'(i_sensor_y);
            r_first <= i_first_point;
        end
        if (i_cmd.setup) begin
            r_sq   <= 34'(34'(r_dx) * 34'(r_dx)) + 34'(34'(r_dy) * 34'(r_dy));
            r_zero <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
            if (r_dx < 0) begin
                r_cx  <= -(43'(r_dx) <<< 14);
                r_cy  <= -(43'(r_dy) <<< 14);
                r_acc <= 32'h80000000;
            end else begin
                r_cx  <= 43'(r_dx) <<< 14;
                r_cy  <= 43'(r_dy) <<< 14;
                r_acc <= 32'h0;
            end
            r_step <= '0;
        end
        if (i_cmd.square) begin
            r_dist_ok <= (r_sq > 34'(34'(i_min_distance) * 34'(i_min_distance)))
                      && (r_sq < 34'(34'(i_max_distance) * 34'(i_max_distance)));
            r_rem     <= '0;
            r_root    <= '0;
            r_sq_step <= '0;
        end
        if (i_cmd.cordic) begin
            if (r_cy >= 0) begin
                r_cx  <= r_cx + w_ys;
                r_cy  <= r_cy - w_xs;
                r_acc <= r_acc + atan_entry(r_step);
            end else begin
                r_cx  <= r_cx - w_ys;
                r_cy  <= r_cy + w_xs;
                r_acc <= r_acc - atan_entry(r_step);
            end
            r_step <= r_step + 5'd1;
            r_dnum <= '0;
        end
        if (i_cmd.sqrt_step) begin
            // Radicand bits taken two at a time from the top of r_sq.
            if (r_sq_step == 5'd0) begin
                if ({34'd0, r_sq[33:32]} >= 36'd1) begin
                    r_rem  <= 34'(r_sq[33:32] - 2'd1);
                    r_root <= 18'd1;
                end else begin
                    r_rem  <= 34'(r_sq[33:32]);
                    r_root <= 18'd0;
                end
            end else if (!w_trial[35]) begin
                r_rem  <= w_trial[33:0];
                r_root <= {w_root2[16:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[31:0], w_low[33:32]};
                r_root <= {w_root2[16:0], 1'b0};
            end
            r_sq_step <= r_sq_step + 5'd1;
            r_dnum    <= 18'({w_diff, 1'b0}) + 18'(w_res >> 1);
            r_quot    <= '0;
            r_drem    <= '0;
            r_dv_step <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_dtrial[17]) begin
                r_drem <= w_dtrial[16:0];
                r_quot <= {r_quot[16:0], 1'b1};
            end else begin
                r_drem <= {r_drem[15:0], r_dnum[17]};
                r_quot <= {r_quot[16:0], 1'b0};
            end
            r_dnum    <= {r_dnum[16:0], 1'b0};
            r_dv_step <= r_dv_step + 5'd1;
        end
    end

    // Beam counter; a first point clears it before its own slot is taken.
    logic [CntW-1:0] w_cnt_base;
    logic            w_base_full;
    assign w_cnt_base  = r_first ? '0 : r_count;
    assign w_base_full = w_cnt_base >= CntW'(MAX_BEAMS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            // Remainder s - r*r exceeds r: round up.
            r_range_q <= (r_rem > 34'(r_root)) ? 17'(r_root + 18'd1) : 17'(r_root);
            r_ang_q   <= w_ang;
            r_idx_q   <= r_quot[15:0];
            r_drop_q  <= w_base_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            if (o_status.keep && !w_base_full) begin
                r_count <= w_cnt_base + CntW'(1);
            end else begin
                r_count <= w_cnt_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (w_base_full) begin
                r_slot_q <= (MAX_BEAMS - 1 > 255) ? 8'd255 : 8'(MAX_BEAMS - 1);
            end else if (32'(w_cnt_base) > 32'd255) begin
                r_slot_q <= 8'd255;
            end else begin
                r_slot_q <= 8'(w_cnt_base);
            end
        end
    end

    assign o_beam_range = r_range_q;
    assign o_beam_angle = r_ang_q;
    assign o_scan_index = r_idx_q;
    assign o_beam_slot  = r_slot_q;
    assign o_dropped    = r_drop_q;

endmodule
`default_nettype wire

FILE: rtl/template_point_to_sensor_beam.sv
`default_nettype none
// Template point to sensor beam. Each slave-side transaction carries one template
// point; the block forms the vector from the configured sensor, finds its bearing
// with a 24-step CORDIC and its range with a bit-serial square root, and, when the
// point lies inside the angle and distance windows, sends one beam transaction with
// the rounded range, bearing, nearest scan index, slot number and a dropped flag
// that is set once MAX_BEAMS beams have been given. Points outside the windows give
// no transaction. Each point passes through the accepting cycle, setup, squaring,
// 24 CORDIC iterations, 17 square-root steps, 18 divider steps for the scan index
// and the output cycle; only one point is in work at a time, and the output cycle waits
// while an earlier beam is still held by the receiver. Configuration must be written over
// the APB port only while the block is idle; the block itself does not enforce this.
module template_point_to_sensor_beam
    import tpsb_pkg::*;
#(
    parameter int MAX_BEAMS = MaxBeamsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
    input  wire logic        s_axis_tuser,   // first_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // beam_range[16:0], beam_angle[32:17],
                                             // scan_index[48:33], beam_slot[56:49]
    output logic             m_axis_tuser,   // dropped
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic signed [15:0] r_sensor_x, r_sensor_y, r_min_angle, r_max_angle;
    logic        [16:0] r_min_distance, r_max_distance;
    logic        [14:0] r_angular_resolution;
    logic        [2:0]  w_reg;

    t_cmd    w_cmd;
    t_status w_status;

    logic [16:0] w_range;
    logic signed [15:0] w_angle;
    logic [15:0] w_idx;
    logic [7:0]  w_slot;
    logic        w_drop;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_x           <= 16'sd0;
            r_sensor_y           <= 16'sd0;
            r_min_angle          <= 16'sh8000;
            r_max_angle          <= 16'sd32767;
            r_min_distance       <= 17'd0;
            r_max_distance       <= 17'd92682;
            r_angular_resolution <= 15'd64;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                RegSensorX:  r_sensor_x           <= pwdata[15:0];
                RegSensorY:  r_sensor_y           <= pwdata[15:0];
                RegMinAngle: r_min_angle          <= pwdata[15:0];
                RegMaxAngle: r_max_angle          <= pwdata[15:0];
                RegMinDist:  r_min_distance       <= pwdata[16:0];
                RegMaxDist:  r_max_distance       <= pwdata[16:0];
                RegAngRes:   r_angular_resolution <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            RegSensorX:  prdata = 32'(unsigned'(r_sensor_x));
            RegSensorY:  prdata = 32'(unsigned'(r_sensor_y));
            RegMinAngle: prdata = 32'(unsigned'(r_min_angle));
            RegMaxAngle: prdata = 32'(unsigned'(r_max_angle));
            RegMinDist:  prdata = 32'(r_min_distance);
            RegMaxDist:  prdata = 32'(r_max_distance);
            RegAngRes:   prdata = 32'(r_angular_resolution);
            default:     prdata = 32'd0;
        endcase
    end

    tpsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tpsb_datapath #(.MAX_BEAMS(MAX_BEAMS)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_point_x            (s_axis_tdata[15:0]),
        .i_point_y            (s_axis_tdata[31:16]),
        .i_first_point        (s_axis_tuser),
        .i_sensor_x           (r_sensor_x),
        .i_sensor_y           (r_sensor_y),
        .i_min_angle          (r_min_angle),
        .i_max_angle          (r_max_angle),
        .i_min_distance       (r_min_distance),
        .i_max_distance       (r_max_distance),
        .i_angular_resolution (r_angular_resolution),
        .o_status             (w_status),
        .o_beam_range         (w_range),
        .o_beam_angle         (w_angle),
        .o_scan_index         (w_idx),
        .o_beam_slot          (w_slot),
        .o_dropped            (w_drop)
    );

    // tdata packs the beam fields from the lowest bit up; the top bits are zero.
    assign m_axis_tdata = {7'd0, w_slot, w_idx, w_angle, w_range};
    assign m_axis_tuser = w_drop;

endmodule
`default_nettype wire

FILE: test/template_point_to_sensor_beam_test.sv
`default_nettype none
module template_point_to_sensor_beam_test
    import tpsb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxBeams   = MaxBeamsDefault;
    // Settle windows leave margin beyond the time one point takes inside the block.
    localparam int SettleCycles = 100;
    localparam int StallLimit   = 4000;
    localparam int HoldCycles   = 400;

    // One template point as the sender offers it.
    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               first;
    } t_point;

    // One beam as the block reports it.
    typedef struct {
        logic [16:0] range;
        logic [15:0] angle;
        logic [15:0] scan;
        logic [7:0]  slot;
        logic        dropped;
    } t_beam;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // point_x[15:0], point_y[31:16]
    logic        s_axis_tuser;   // first_point
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // beam_range[16:0], beam_angle[32:17],
                                 // scan_index[48:33], beam_slot[56:49]
    logic        m_axis_tuser;   // dropped
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    template_point_to_sensor_beam i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Shadow copy of the configuration and the beam counter.
    logic signed [15:0] sh_sensor_x;
    logic signed [15:0] sh_sensor_y;
    logic signed [15:0] sh_min_angle;
    logic signed [15:0] sh_max_angle;
    logic [16:0]        sh_min_dist;
    logic [16:0]        sh_max_dist;
    logic [14:0]        sh_ang_res;
    int unsigned        sh_beam_count;

    t_point pending_points[$];
    t_beam  expected_beams[$];

    int  error_count;
    bit  no_idle;
    bit  hold_req;
    bit  activity;
    t_point on_bus;

    logic [31:0] atan_steps [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Bearing of (dx, dy) by vectoring rotations, 2^32 per full turn in the accumulator.
    function automatic logic signed [15:0] vector_bearing(longint dx, longint dy);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] acc;
        logic [31:0] rounded;
        vx = dx * 16384;
        vy = dy * 16384;
        acc = '0;
        if (dx == 0 && dy == 0) begin
            return '0;
        end
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            acc = 32'h80000000;
        end
        for (int i = 0; i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy;
                vy = vy - sx;
                acc = acc + atan_steps[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                acc = acc - atan_steps[i];
            end
        end
        rounded = acc + 32'h8000;
        return rounded[31:16];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Splits a packed beam: range, angle, scan index, slot, then the dropped flag.
    function automatic t_beam unpack_beam(logic [63:0] w);
        t_beam b;
        b.range   = w[16:0];
        b.angle   = w[32:17];
        b.scan    = w[48:33];
        b.slot    = w[56:49];
        b.dropped = w[57];
        return b;
    endfunction

    // Works out the beam for one accepted point and advances the beam counter.
    function automatic void predict_beam(t_point p);
        longint            dx;
        longint            dy;
        longint unsigned   sq;
        longint unsigned   r;
        longint unsigned   rng;
        longint unsigned   res;
        longint unsigned   idx;
        logic signed [15:0] ang;
        int unsigned       slot;
        bit                full;
        logic [63:0]       w;
        dx = longint'(p.px) - longint'(sh_sensor_x);
        dy = longint'(p.py) - longint'(sh_sensor_y);
        sq = dx * dx + dy * dy;
        if (p.first) begin
            sh_beam_count = 0;
        end
        ang = vector_bearing(dx, dy);
        if (ang < sh_min_angle || ang > sh_max_angle) begin
            return;
        end
        if (!(sq > longint'(sh_min_dist) * longint'(sh_min_dist))) begin
            return;
        end
        if (!(sq < longint'(sh_max_dist) * longint'(sh_max_dist))) begin
            return;
        end
        r = int_sqrt(sq);
        rng = (sq - r * r > r) ? r + 1 : r;
        res = (sh_ang_res == 0) ? 1 : sh_ang_res;
        idx = (2 * longint'(longint'(ang) - longint'(sh_min_angle)) + res) / (2 * res);
        full = sh_beam_count >= MaxBeams;
        slot = full ? MaxBeams - 1 : sh_beam_count;
        if (slot > 255) begin
            slot = 255;
        end
        if (!full) begin
            sh_beam_count++;
        end
        w = {6'b0, full, slot[7:0], idx[15:0], ang, rng[16:0]};
        expected_beams.push_back(unpack_beam(w));
    endfunction

    // Sender: offers queued points, with random gaps unless idling is switched off.
    int     send_gap;
    always @(posedge i_clk) begin
        bit     took;
        bit     next_valid;
        t_point nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap = 0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            if (took) begin
                predict_beam(on_bus);
            end
            next_valid = s_axis_tvalid && !took;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_points.size() != 0 && !no_idle
                             && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 14);
                end else if (pending_points.size() != 0) begin
                    nxt = pending_points.pop_front();
                    on_bus = nxt;
                    next_valid = 1'b1;
                    s_axis_tdata <= {nxt.py, nxt.px};
                    s_axis_tuser <= nxt.first;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Receiver: checks each beam transaction and stalls at random or on request.
    int recv_gap;
    int hold_left;
    always @(posedge i_clk) begin
        t_beam got;
        t_beam want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = unpack_beam({6'b0, m_axis_tuser, m_axis_tdata[56:0]});
                if (expected_beams.size() == 0) begin
                    $error("beam transaction with nothing expected: range %0d angle %0d",
                           got.range, got.angle);
                    error_count++;
                end else begin
                    want = expected_beams.pop_front();
                    if (got.range !== want.range) begin
                        $error("beam_range expected %0d actual %0d", want.range, got.range);
                        error_count++;
                    end
                    if (got.angle !== want.angle) begin
                        $error("beam_angle expected %0d actual %0d",
                               $signed(want.angle), $signed(got.angle));
                        error_count++;
                    end
                    if (got.scan !== want.scan) begin
                        $error("scan_index expected %0d actual %0d", want.scan, got.scan);
                        error_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("beam_slot expected %0d actual %0d", want.slot, got.slot);
                        error_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
                        error_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any transaction or register access restarts the count.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || activity) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        activity <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // The register takes the value at this edge.
        case (idx)
            RegSensorX:  sh_sensor_x  = value[15:0];
            RegSensorY:  sh_sensor_y  = value[15:0];
            RegMinAngle: sh_min_angle = value[15:0];
            RegMaxAngle: sh_max_angle = value[15:0];
            RegMinDist:  sh_min_dist  = value[16:0];
            RegMaxDist:  sh_max_dist  = value[16:0];
            RegAngRes:   sh_ang_res   = value[14:0];
            default: ;
        endcase
        psel     <= 1'b0;
        penable  <= 1'b0;
        activity <= 1'b0;
    endtask

    task automatic set_window(int sx, int sy, int amin, int amax, int dmin, int dmax, int res);
        write_reg(RegSensorX, sx);
        write_reg(RegSensorY, sy);
        write_reg(RegMinAngle, amin);
        write_reg(RegMaxAngle, amax);
        write_reg(RegMinDist, dmin);
        write_reg(RegMaxDist, dmax);
        write_reg(RegAngRes, res);
    endtask

    // Blocks until the block has gone quiet, so that registers may be rewritten.
    task automatic drain();
        while (pending_points.size() != 0 || s_axis_tvalid || expected_beams.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_point(logic [15:0] x, logic [15:0] y, logic first);
        t_point p;
        p.px = x;
        p.py = y;
        p.first = first;
        pending_points.push_back(p);
    endtask

    // Random points; a new template starts every templ_len points, or now and then when templ_len is zero.
    task automatic add_random(int count, int templ_len);
        for (int i = 0; i < count; i++) begin
            add_point(pick_coord(), pick_coord(),
                      templ_len == 0 ? ($urandom_range(0, 19) == 0)
                                     : ((i % templ_len) == 0));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        hold_req      = 1'b0;
        activity      = 1'b0;
        no_idle       = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        sh_sensor_x   = 0;
        sh_sensor_y   = 0;
        sh_min_angle  = -32768;
        sh_max_angle  = 32767;
        sh_min_dist   = 0;
        sh_max_dist   = 92682;
        sh_ang_res    = 64;
        sh_beam_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset window: the zero vector, the four axes,
        // the bearing of exactly pi, the corner extremes and the template start flag.
        add_point(16'h0000, 16'h0000, 1'b1);
        add_point(16'h0100, 16'h0000, 1'b0);
        add_point(16'h0000, 16'h0100, 1'b0);
        add_point(16'hFF00, 16'h0000, 1'b0);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h0000, 16'hFF00, 1'b0);
        add_point(16'h7FFF, 16'h7FFF, 1'b0);
        add_point(16'h8000, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b1);
        add_point(16'h7FFF, 16'h8000, 1'b0);
        add_point(16'hFFFF, 16'hFFFF, 1'b0);
        add_point(16'h0001, 16'h0001, 1'b0);
        add_point(16'h8000, 16'h0001, 1'b0);
        add_point(16'h8000, 16'hFFFF, 1'b0);
        drain();

        // Sensor in a far corner, so the distance reaches its largest values, just inside
        // the far end of the distance window.
        set_window(-32768, -32768, -32768, 32767, 0, 92682, 1);
        add_point(16'h7FFF, 16'h7FFF, 1'b1);
        add_point(16'h8000, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b0);
        add_random(60, 0);
        drain();
        set_window(-32768, -32768, -32768, 32767, 100, 92681, 32767);
        add_point(16'h7FFF, 16'h7FFF, 1'b0);
        add_random(40, 0);
        drain();

        // Narrow windows; the receiver holds off long enough to back the block up.
        set_window($urandom_range(0, 65535), $urandom_range(0, 65535),
                   -8192, 8192, 4000, 30000, 0);
        fork
            add_random(100, 12);
            begin
                repeat (50) @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
        join
        drain();

        // Reversed windows keep nothing.
        set_window(100, -100, 32767, -32768, 0, 92682, 64);
        add_random(25, 0);
        drain();
        set_window(100, -100, -32768, 32767, 5000, 5000, 64);
        add_random(25, 0);
        drain();

        // One long template past the beam table size, so later beams are dropped.
        set_window(0, 0, -32768, 32767, 0, 92682, 200);
        add_random(300, 0);
        for (int i = 0; i < 300; i++) begin
            pending_points[pending_points.size() - 300 + i].first = (i == 0);
        end
        drain();

        // Random settings, then a final stretch without idling.
        set_window($urandom(), $urandom(), $urandom_range(0, 65535) - 32768, 32767,
                   $urandom_range(0, 2000), $urandom_range(40000, 92682),
                   $urandom_range(1, 32767));
        add_random(60, 20);
        drain();
        no_idle = 1'b1;
        add_random(40, 10);
        drain();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: template_point_to_sensor_beam.f
rtl/tpsb_pkg.sv
rtl/tpsb_ctrl.sv
rtl/tpsb_datapath.sv
rtl/template_point_to_sensor_beam.sv
test/template_point_to_sensor_beam_test.sv
